// ===== rtl/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

  localparam int PAGES     = 4096;
  localparam int MAX_ORDER = 8;
  localparam int AW        = $clog2(PAGES);
  localparam int LW        = AW + 1;
  localparam int OW        = 4;
  localparam int KW        = $clog2(MAX_ORDER + 1);
  localparam int ZW        = 5;
  localparam int BW        = AW - MAX_ORDER;

  localparam logic [LW-1:0] NIL = LW'(PAGES);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_BAD_ORD  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OW-1:0] ord;
    logic          free;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } node_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    node_t         wdata;
  } mem_req_t;

  typedef struct packed {
    status_t       status;
    logic [AW-1:0] page;
    logic [OW-1:0] order;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/bpa_mem.sv =====
`default_nettype none
module bpa_mem (
  input  wire logic            clk,
  input  wire bpa_pkg::mem_req_t req,
  output bpa_pkg::node_t       rdata
);
  import bpa_pkg::*;

  node_t mem [PAGES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
`default_nettype none
module bpa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  init_start,
  input  wire logic [bpa_pkg::ZW-1:0] zone,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [bpa_pkg::OW-1:0] in_order,
  input  wire logic [bpa_pkg::AW-1:0] in_page,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output bpa_pkg::result_t           res,
  output logic                       idle,
  output bpa_pkg::mem_req_t          mreq,
  input  wire bpa_pkg::node_t        rdata
);
  import bpa_pkg::*;

  typedef enum logic [20:0] {
    S_INIT   = 21'd1 << 0,
    S_IDLE   = 21'd1 << 1,
    S_A_RD   = 21'd1 << 2,
    S_A_WP   = 21'd1 << 3,
    S_UL_PR  = 21'd1 << 4,
    S_UL_PRW = 21'd1 << 5,
    S_UL_NX  = 21'd1 << 6,
    S_UL_NXW = 21'd1 << 7,
    S_UL_END = 21'd1 << 8,
    S_A_SPL  = 21'd1 << 9,
    S_PS_WR  = 21'd1 << 10,
    S_PS_TRD = 21'd1 << 11,
    S_PS_TWR = 21'd1 << 12,
    S_PS_END = 21'd1 << 13,
    S_F_RD   = 21'd1 << 14,
    S_F_CHK  = 21'd1 << 15,
    S_F_LOOP = 21'd1 << 16,
    S_F_BCHK = 21'd1 << 17,
    S_DONE   = 21'd1 << 18,
    S_SPARE0 = 21'd1 << 19,
    S_SPARE1 = 21'd1 << 20
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt, x, p;
  logic [LW-1:0] pr, nx;
  logic [KW-1:0] k;
  logic [OW-1:0] req;
  logic          op_r;
  logic [LW-1:0] tail [MAX_ORDER+1];
  logic [MAX_ORDER:0] avail;

  logic [KW-1:0] found;
  logic          any;
  logic [BW-1:0] blk;
  logic          is_start, in_zone;
  node_t         init_word;
  logic [AW-1:0] bit_k, bit_km1;
  logic [KW-1:0] rd_k;

  always_comb begin
    found = '0;
    any   = 1'b0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (avail[i] && OW'(i) >= in_order) begin
        found = KW'(i);
        any   = 1'b1;
      end
    end
  end

  assign bit_k   = AW'(1) << k;
  assign bit_km1 = AW'(1) << (k - KW'(1));
  assign rd_k    = (rdata.ord > OW'(MAX_ORDER)) ? KW'(MAX_ORDER) : KW'(rdata.ord);

  // reset layout of one page
  always_comb begin
    blk       = cnt[AW-1:MAX_ORDER];
    is_start  = cnt[MAX_ORDER-1:0] == '0;
    in_zone   = ZW'(blk) < zone;
    init_word.ord  = is_start ? OW'(MAX_ORDER) : '0;
    init_word.free = is_start && in_zone;
    init_word.nxt  = (is_start && in_zone && (ZW'(blk) + ZW'(1) < zone))
                     ? {1'b0, BW'(blk + BW'(1)), {MAX_ORDER{1'b0}}} : NIL;
    init_word.prv  = (is_start && in_zone && blk != '0)
                     ? {1'b0, BW'(blk - BW'(1)), {MAX_ORDER{1'b0}}} : NIL;
  end

  always_comb begin
    mreq       = '0;
    mreq.raddr = x;
    mreq.waddr = x;
    unique case (state)
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = cnt;
        mreq.wdata = init_word;
      end
      S_A_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = tail[k][AW-1:0];
      end
      S_A_WP: begin
        mreq.we    = 1'b1;
        mreq.wdata = '{ord: req, free: 1'b0, nxt: NIL, prv: NIL};
      end
      S_UL_PR: begin
        mreq.re    = !pr[AW];
        mreq.raddr = pr[AW-1:0];
      end
      S_UL_PRW: begin
        mreq.we        = 1'b1;
        mreq.waddr     = pr[AW-1:0];
        mreq.wdata     = rdata;
        mreq.wdata.nxt = nx;
      end
      S_UL_NX: begin
        mreq.re    = !nx[AW];
        mreq.raddr = nx[AW-1:0];
      end
      S_UL_NXW: begin
        mreq.we        = 1'b1;
        mreq.waddr     = nx[AW-1:0];
        mreq.wdata     = rdata;
        mreq.wdata.prv = pr;
      end
      S_PS_WR: begin
        mreq.we    = 1'b1;
        mreq.wdata = '{ord: OW'(k), free: 1'b1, nxt: NIL, prv: tail[k]};
      end
      S_PS_TRD: begin
        mreq.re    = 1'b1;
        mreq.raddr = tail[k][AW-1:0];
      end
      S_PS_TWR: begin
        mreq.we        = 1'b1;
        mreq.waddr     = tail[k][AW-1:0];
        mreq.wdata     = rdata;
        mreq.wdata.nxt = {1'b0, x};
      end
      S_F_RD: begin
        mreq.re = 1'b1;
      end
      S_F_LOOP: begin
        mreq.re    = k < KW'(MAX_ORDER);
        mreq.raddr = p ^ bit_k;
      end
      S_F_BCHK: begin
        mreq.we    = (rdata.ord == OW'(k)) && rdata.free;
        mreq.wdata = '{ord: rdata.ord, free: 1'b0, nxt: NIL, prv: NIL};
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE) && !init_start;
  assign idle      = (state == S_IDLE) || (state == S_INIT);
  assign res_valid = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          cnt <= cnt + AW'(1);
          for (int i = 0; i <= MAX_ORDER; i++) begin
            tail[i]  <= NIL;
            avail[i] <= 1'b0;
          end
          tail[MAX_ORDER]  <= {1'b0, BW'(zone - ZW'(1)), {MAX_ORDER{1'b0}}};
          avail[MAX_ORDER] <= 1'b1;
          if (init_start) begin
            cnt <= '0;
          end else if (cnt == AW'(PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (init_start) begin
            cnt   <= '0;
            state <= S_INIT;
          end else if (in_valid) begin
            op_r <= in_op;
            req  <= in_order;
            p    <= in_page;
            x    <= in_page;
            res  <= '0;
            if (in_op == OP_ALLOC) begin
              if (in_order > OW'(MAX_ORDER)) begin
                res.status <= ST_BAD_ORD;
                state      <= S_DONE;
              end else if (!any) begin
                res.status <= ST_NO_BLOCK;
                state      <= S_DONE;
              end else begin
                k     <= found;
                state <= S_A_RD;
              end
            end else begin
              if (ZW'(in_page[AW-1:MAX_ORDER]) >= zone) begin
                res.status <= ST_OUTSIDE;
                state      <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          x     <= tail[k][AW-1:0];
          state <= S_A_WP;
        end
        S_A_WP: begin
          pr    <= rdata.prv;
          nx    <= rdata.nxt;
          p     <= x;
          state <= S_UL_PR;
        end
        S_UL_PR:  state <= pr[AW] ? S_UL_NX : S_UL_PRW;
        S_UL_PRW: state <= S_UL_NX;
        S_UL_NX: begin
          if (nx[AW]) begin
            // node was the tail of its list
            tail[k]  <= pr;
            avail[k] <= !pr[AW];
            state    <= S_UL_END;
          end else begin
            state <= S_UL_NXW;
          end
        end
        S_UL_NXW: state <= S_UL_END;
        S_UL_END: begin
          if (op_r == OP_ALLOC) begin
            state <= S_A_SPL;
          end else begin
            p     <= p & x;
            k     <= k + KW'(1);
            state <= S_F_LOOP;
          end
        end
        S_A_SPL: begin
          if (OW'(k) > req) begin
            k     <= k - KW'(1);
            x     <= p ^ bit_km1;
            state <= S_PS_WR;
          end else begin
            res   <= '{status: ST_OK, page: p, order: req};
            state <= S_DONE;
          end
        end
        S_PS_WR: begin
          if (tail[k][AW]) begin
            tail[k]  <= {1'b0, x};
            avail[k] <= 1'b1;
            state    <= S_PS_END;
          end else begin
            state <= S_PS_TRD;
          end
        end
        S_PS_TRD: state <= S_PS_TWR;
        S_PS_TWR: begin
          tail[k]  <= {1'b0, x};
          avail[k] <= 1'b1;
          state    <= S_PS_END;
        end
        S_PS_END: begin
          if (op_r == OP_ALLOC) begin
            state <= S_A_SPL;
          end else begin
            res   <= '{status: ST_OK, page: p, order: OW'(k)};
            state <= S_DONE;
          end
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (rdata.free) begin
            res.status <= ST_NO_BLOCK;
            state      <= S_DONE;
          end else begin
            k     <= rd_k;
            state <= S_F_LOOP;
          end
        end
        S_F_LOOP: begin
          if (k < KW'(MAX_ORDER)) begin
            x     <= p ^ bit_k;
            state <= S_F_BCHK;
          end else begin
            x     <= p;
            state <= S_PS_WR;
          end
        end
        S_F_BCHK: begin
          if ((rdata.ord == OW'(k)) && rdata.free) begin
            pr    <= rdata.prv;
            nx    <= rdata.nxt;
            state <= S_UL_PR;
          end else begin
            x     <= p;
            state <= S_PS_WR;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mreq.re && mreq.we))
    else $error("memory read and write in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_A_RD |-> !tail[k][AW] && avail[k])
    else $error("pop from an empty list");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> state == S_IDLE)
    else $error("result taken but sequencer not idle");

  a_init_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> state == S_INIT)
    else $error("no clearing pass after reset");

endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
// Channel   Dir  tdata / data               tuser
// s_axis    in   [3:0] order, [15:4] page    [0] op
// m_axis    out  [11:0] block_page,          [1:0] status
//                [15:12] block_order
// cfg       in   [4:0] zone_blocks           -
//
// Allocations that split and frees that merge walk their chain step by
// step: each step reads then writes the page memory, one access a
// cycle, plus read-modify-writes of neighbor links.
// After reset and after each cfg write a clearing pass rewrites every
// page of the page memory; no item is taken during it.
// One item is in work at a time; a new item is taken while the result
// waits in the output register.
`default_nettype none
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // order[3:0], page[15:4]
  input  wire logic [0:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // block_page[11:0], block_order[15:12]
  output logic [1:0]       m_axis_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import bpa_pkg::*;

  localparam logic [ZW-1:0] TOP_BLOCKS = ZW'(PAGES >> MAX_ORDER);

  logic [ZW-1:0] zone, zone_next;
  logic          cfg_wr, ctrl_idle, res_valid, res_ready;
  result_t       res;
  mem_req_t      mreq;
  node_t         rdata;

  always_comb begin
    zone_next = cfg_data;
    if (cfg_data == '0) begin
      zone_next = ZW'(1);
    end else if (cfg_data > TOP_BLOCKS) begin
      zone_next = TOP_BLOCKS;
    end
  end

  assign cfg_ready = ctrl_idle;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= TOP_BLOCKS;
    end else if (cfg_wr) begin
      zone <= zone_next;
    end
  end

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {res.order, res.page};
      m_axis_tuser <= res.status;
    end
  end

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .init_start (cfg_wr),
    .zone       (zone),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser[0]),
    .in_order   (s_axis_tdata[3:0]),
    .in_page    (s_axis_tdata[15:4]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .idle       (ctrl_idle),
    .mreq       (mreq),
    .rdata      (rdata)
  );

  bpa_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

// ===== tb/bpa_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module bpa_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // order[3:0], page[15:4]
  input  wire logic [0:0]  s_axis_tuser,  // op
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,  // block_page[11:0], block_order[15:12]
  input  wire logic [1:0]  m_axis_tuser,  // status
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [4:0]  cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count
);
  import bpa_pkg::*;

  localparam int TOPB = PAGES >> MAX_ORDER;

  logic [3:0]    pg_ord [PAGES];
  logic          pg_free[PAGES];
  logic [LW-1:0] nxt[PAGES];
  logic [LW-1:0] prv[PAGES];
  logic [LW-1:0] head[MAX_ORDER+1];
  logic [LW-1:0] tail[MAX_ORDER+1];
  int            zone;
  result_t       want_q[$];

  function automatic void list_append(int o, int p);
    logic [LW-1:0] t;
    t = tail[o];
    prv[p] = t;
    nxt[p] = NIL;
    if (t < PAGES) nxt[t] = LW'(p);
    else head[o] = LW'(p);
    tail[o] = LW'(p);
  endfunction

  function automatic void list_remove(int o, int p);
    logic [LW-1:0] pr, nx;
    pr = prv[p];
    nx = nxt[p];
    if (pr < PAGES) nxt[pr] = nx;
    else head[o] = nx;
    if (nx < PAGES) prv[nx] = pr;
    else tail[o] = pr;
    prv[p] = NIL;
    nxt[p] = NIL;
  endfunction

  function automatic void zone_layout(int nb);
    zone = nb < 1 ? 1 : (nb > TOPB ? TOPB : nb);
    for (int i = 0; i < PAGES; i++) begin
      pg_ord[i] = 0;
      pg_free[i] = 0;
      nxt[i] = NIL;
      prv[i] = NIL;
    end
    for (int i = 0; i <= MAX_ORDER; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
    end
    for (int i = 0; i < TOPB; i++) pg_ord[i << MAX_ORDER] = MAX_ORDER;
    for (int i = 0; i < zone; i++) begin
      pg_free[i << MAX_ORDER] = 1;
      list_append(MAX_ORDER, i << MAX_ORDER);
    end
  endfunction

  function automatic result_t buddy_step(logic op, int req, int pg);
    result_t r;
    int found, p, k, b;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      found = MAX_ORDER + 1;
      if (req > MAX_ORDER) r.status = ST_BAD_ORD;
      else begin
        for (int o = req; o <= MAX_ORDER; o++)
          if (found > MAX_ORDER && tail[o] < PAGES) found = o;
        if (found > MAX_ORDER) r.status = ST_NO_BLOCK;
        else begin
          p = tail[found];
          list_remove(found, p);
          pg_free[p] = 0;
          while (found > req) begin
            found--;
            b = p ^ (1 << found);
            pg_ord[b] = 4'(found);
            pg_free[b] = 1;
            list_append(found, b);
          end
          pg_ord[p] = 4'(req);
          r.page = AW'(p);
          r.order = OW'(req);
        end
      end
    end else begin
      if (pg >= (zone << MAX_ORDER)) r.status = ST_OUTSIDE;
      else if (pg_free[pg]) r.status = ST_NO_BLOCK;
      else begin
        p = pg;
        k = pg_ord[pg];
        if (k > MAX_ORDER) k = MAX_ORDER;
        while (k < MAX_ORDER && pg_ord[p ^ (1 << k)] == k && pg_free[p ^ (1 << k)]) begin
          b = p ^ (1 << k);
          list_remove(k, b);
          pg_free[b] = 0;
          p = p & b;
          k++;
        end
        pg_ord[p] = 4'(k);
        pg_free[p] = 1;
        list_append(k, p);
        r.page = AW'(p);
        r.order = OW'(k);
      end
    end
    return r;
  endfunction

  initial zone_layout(TOPB);

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      zone_layout(TOPB);
      fail_count <= 0;
      result_count <= 0;
      want_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) zone_layout(int'(cfg_data));
      if (s_axis_tvalid && s_axis_tready)
        want_q.push_back(buddy_step(s_axis_tuser[0], int'(s_axis_tdata[3:0]),
                                    int'(s_axis_tdata[15:4])));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tuser);
        got.page = m_axis_tdata[11:0];
        got.order = m_axis_tdata[15:12];
        result_count <= result_count + 1;
        if (want_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: status exp %0d got %0d, page exp %0d got %0d, %s %0d got %0d",
                       want.status, got.status, want.page, got.page, "order exp",
                       want.order, got.order);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= want_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bpa_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  int          fail_count, pending, result_count;
  logic        stall_req = 0;
  logic        stall_done = 0;
  int          stall_left = 0;
  int          n_items = 0;
  int          live[$];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  buddy_page_allocator u_dut (.*);

  bpa_checker u_chk (.*);

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random stalls, plus one long hold-off requested by stimulus
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (stall_req && !stall_done) begin
      stall_done <= 1;
      stall_left <= 300;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(0, 3) != 0) ||
                              ($urandom_range(0, 1) == 0 && pending > 0);
  end

  // tvalid stays high between items sent back to back
  task automatic send_item(logic op, logic [3:0] ord, logic [11:0] pg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {pg, ord};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending > 0 || s_axis_tvalid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_zone(logic [4:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    live.delete();
  endtask

  task automatic random_phase(int count, int zb);
    int zp, r, idx;
    logic [11:0] pg;
    zp = zb << MAX_ORDER;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_item(OP_ALLOC, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                  : 4'($urandom_range(0, 4)), 12'($urandom));
      end else if (r < 85 && live.size() > 0) begin
        idx = $urandom_range(0, live.size() - 1);
        pg = 12'(live[idx]);
        live.delete(idx);
        send_item(OP_FREE, 4'($urandom), pg);
      end else begin
        pg = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, zp - 1));
        send_item(OP_FREE, 4'($urandom), pg);
      end
      // keep a plausible block start around to free later
      if (r < 50) live.push_back($urandom_range(0, zp - 1) & ~((1 << $urandom_range(0, 4)) - 1));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed
    send_item(OP_ALLOC, 4'd15, 12'hfff);
    send_item(OP_ALLOC, 4'd9, 12'h000);
    send_item(OP_FREE, 4'd0, 12'h000);
    send_item(OP_ALLOC, 4'd0, 12'h000);
    send_item(OP_ALLOC, 4'd0, 12'h000);
    send_item(OP_FREE, 4'd0, 12'hf00);
    send_item(OP_FREE, 4'd0, 12'hfff);
    send_item(OP_FREE, 4'd0, 12'hf01);
    send_item(OP_ALLOC, 4'd8, 12'h000);
    send_item(OP_FREE, 4'd0, 12'h003);
    write_zone(5'd1);
    send_item(OP_ALLOC, 4'd8, 12'h000);
    send_item(OP_ALLOC, 4'd0, 12'h000);
    send_item(OP_FREE, 4'd0, 12'h100);
    send_item(OP_FREE, 4'd15, 12'h000);
    send_item(OP_ALLOC, 4'd0, 12'h000);
    send_item(OP_ALLOC, 4'd1, 12'h000);
    send_item(OP_FREE, 4'd0, 12'h0ff);
    send_item(OP_FREE, 4'd0, 12'h0fe);
    write_zone(5'd0);
    send_item(OP_ALLOC, 4'd8, 12'h000);
    send_item(OP_ALLOC, 4'd8, 12'h000);
    write_zone(5'd31);
    // pressure: receiver stalls while sender keeps offering
    stall_req <= 1;
    for (int i = 0; i < 12; i++) send_item(OP_ALLOC, 4'(i % 4), 12'h000);
    random_phase(400, 16);
    write_zone(5'd1);
    random_phase(400, 1);
    write_zone(5'd3);
    random_phase(400, 3);
    write_zone(5'd16);
    random_phase(350, 16);
    write_zone(5'd8);
    random_phase(350, 8);
    drain();
    $display("%0d items sent, %0d results checked over zones of 1, 3, 8 and 16 blocks",
             n_items, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
